FILE: hw/rtl/gtg_pkg.sv
// gtg_pkg: shared types, codes and constants of the go-to-goal steering controller
// depends on nothing; imported by go_to_goal_steering_controller
`timescale 1ns / 1ps

package gtg_pkg;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQUARE_X,
      ST_SQUARE_Y,
      ST_ROOT,
      ST_ARRIVE,
      ST_NORM,
      ST_ROTATE,
      ST_ANGLE,
      ST_WRAP,
      ST_MUL_ANG,
      ST_MUL_LIN,
      ST_CLAMP,
      ST_FINISH
   } state_type;

   // event kinds
   localparam logic [1:0] CMD_GOAL = 2'd0;
   localparam logic [1:0] CMD_SCAN = 2'd1;
   localparam logic [1:0] CMD_TICK = 2'd2;

   // result status codes
   localparam logic [2:0] STAT_NO_GOAL  = 3'd0;
   localparam logic [2:0] STAT_NO_POSE  = 3'd1;
   localparam logic [2:0] STAT_REACHED  = 3'd2;
   localparam logic [2:0] STAT_BLOCKED  = 3'd3;
   localparam logic [2:0] STAT_TURNING  = 3'd4;
   localparam logic [2:0] STAT_DRIVING  = 3'd5;

   // register indexes
   localparam logic [2:0] REG_MAX_LIN   = 3'd0;
   localparam logic [2:0] REG_MAX_TURN  = 3'd1;
   localparam logic [2:0] REG_LIN_GAIN  = 3'd2;
   localparam logic [2:0] REG_TURN_GAIN = 3'd3;
   localparam logic [2:0] REG_ARRIVE    = 3'd4;
   localparam logic [2:0] REG_HEAD_TOL  = 3'd5;
   localparam logic [2:0] REG_SAFE_DIST = 3'd6;

   localparam int CORDIC_STEPS = 20;
   localparam logic signed [27:0] PI_Q24 = 28'sd52707179;
   localparam logic signed [18:0] PI_Q13 = 19'sd25736;
   localparam logic signed [18:0] TWO_PI_Q13 = 19'sd51472;
   localparam logic signed [15:0] FRONT_HALF_ANGLE = 16'sd4289;
   localparam logic signed [23:0] BLOCKED_TURN = 24'sd3277;
   localparam logic [23:0] RANGE_INF = 24'hFFFFFF;

   // arctangent of 2^-i in units of 2^-24 rad
   function automatic logic signed [27:0] atan_entry(input logic [4:0] idx);
      logic signed [27:0] val;
      case (idx)
         5'd0:  val = 28'sd13176795;
         5'd1:  val = 28'sd7778716;
         5'd2:  val = 28'sd4110060;
         5'd3:  val = 28'sd2086331;
         5'd4:  val = 28'sd1047214;
         5'd5:  val = 28'sd524117;
         5'd6:  val = 28'sd262123;
         5'd7:  val = 28'sd131069;
         5'd8:  val = 28'sd65536;
         5'd9:  val = 28'sd32768;
         5'd10: val = 28'sd16384;
         5'd11: val = 28'sd8192;
         5'd12: val = 28'sd4096;
         5'd13: val = 28'sd2048;
         5'd14: val = 28'sd1024;
         5'd15: val = 28'sd512;
         5'd16: val = 28'sd256;
         5'd17: val = 28'sd128;
         5'd18: val = 28'sd64;
         5'd19: val = 28'sd32;
         default: val = 28'sd0;
      endcase
      return val;
   endfunction

endpackage

FILE: hw/rtl/go_to_goal_steering_controller.sv
// go_to_goal_steering_controller: proportional go-to-goal steering with front obstacle stop
// depends on gtg_pkg (state type, codes, constants, arctangent table)
`timescale 1ns / 1ps

// usage
// req_ channel carries one transaction per event: a goal (stores the goal, arms the block),
// a scan sample (updates the front running minimum, the last sample commits it) or a
// control tick (pose in, one velocity command out on the rsp_ channel)
// goal and scan transactions finish in the accepting cycle and give no result
// a control tick runs a sequencer: two squares on one multiplier, a 25 step
// square root one bit pair per cycle, a left normalisation one bit per cycle (0 to 30),
// 20 cordic vectoring steps one per cycle, wrap, two gain products and a clamp
// so a tick ends in the finish state, which loads the result register;
// disarmed and invalid-pose ticks go straight to that state, a reached goal right after the arrival check
// req_stall is high while a tick is in flight, so one tick is worked on at a time
// the result sits in an output register: a stalled rsp_ side holds it, and the
// block still takes the next transaction; a later tick waits only at its very end
// csr_ writes are always taken (csr_ready high) and must come while the block is idle
// reset (synchronous) restores the register defaults, disarms the goal, sets both
// range minimums to infinity and forgets any committed scan

module go_to_goal_steering_controller
   import gtg_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_cmd,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [15:0] req_heading,
   input  logic               req_pose_valid,
   input  logic [23:0]        req_sample_range,
   input  logic               req_range_valid,
   input  logic signed [15:0] req_sample_angle,
   input  logic               req_scan_first,
   input  logic               req_scan_last,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [23:0] rsp_lin_vel,
   output logic signed [15:0] rsp_ang_vel,
   output logic [2:0]         rsp_status,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [23:0]        csr_wdata
);

   // configuration registers
   logic [22:0] max_lin_ff;
   logic [14:0] max_turn_ff;
   logic [15:0] lin_gain_ff;
   logic [15:0] turn_gain_ff;
   logic [23:0] arrive_tol_ff;
   logic [14:0] head_tol_ff;
   logic [23:0] safe_dist_ff;

   // goal and scan state
   logic signed [31:0] goal_x_ff;
   logic signed [31:0] goal_y_ff;
   logic               armed_ff;
   logic [23:0]        run_min_ff;
   logic [23:0]        front_min_ff;
   logic               scan_seen_ff;

   // tick datapath
   state_type          state_ff, state_in;
   logic signed [32:0] dx_ff, dy_ff;
   logic signed [15:0] heading_ff;
   logic               far_ff;
   logic [49:0]        rem_ff, root_ff, bit_ff;
   logic [23:0]        dist_ff;
   logic signed [35:0] cx_ff, cy_ff;
   logic signed [27:0] cz_ff;
   logic [4:0]         step_ff;
   logic signed [18:0] err_ff;
   logic signed [35:0] prod_ang_ff;
   logic [39:0]        prod_lin_ff;
   logic [2:0]         mode_ff;
   logic signed [23:0] out_lin_ff;
   logic signed [15:0] out_ang_ff;

   // result register
   logic               rsp_valid_ff;
   logic signed [23:0] rsp_lin_ff;
   logic signed [15:0] rsp_ang_ff;
   logic [2:0]         rsp_status_ff;

   // control outputs of the sequencer
   logic idle, load_rsp;

   // combinational helpers
   logic signed [32:0] dx_new, dy_new;
   logic [32:0]        ax, ay;
   logic [23:0]        sq_op;
   logic [47:0]        sq_prod;
   logic [49:0]        trial;
   logic               root_take;
   logic [23:0]        dist_val;
   logic               reached, zero_vec;
   logic               normalised;
   logic signed [35:0] cx_sh, cy_sh;
   logic signed [27:0] z_round;
   logic signed [18:0] angle_q13;
   logic               wrap_hi, wrap_lo;
   logic               blocked, over_tol;
   logic signed [35:0] ang_round;
   logic [39:0]        lin_round;
   logic signed [23:0] ang_r, ang_src, ang_c, turn_lim;
   logic [27:0]        lin_r;
   logic [23:0]        lin_c;
   logic [23:0]        scan_start, scan_cand;
   logic               in_window;

   // tick operands: differences are exact in 33 bits
   assign dx_new = 33'(goal_x_ff) - 33'(req_pos_x);
   assign dy_new = 33'(goal_y_ff) - 33'(req_pos_y);
   assign ax = dx_ff[32] ? 33'(-dx_ff) : 33'(dx_ff);
   assign ay = dy_ff[32] ? 33'(-dy_ff) : 33'(dy_ff);

   // one squarer shared by both axes
   assign sq_op   = (state_ff == ST_SQUARE_X) ? ax[23:0] : ay[23:0];
   assign sq_prod = sq_op * sq_op;

   // square root, one result bit per cycle
   assign trial     = root_ff + bit_ff;
   assign root_take = rem_ff >= trial;

   assign dist_val = (far_ff || (root_ff[49:24] != 26'd0)) ? RANGE_INF : root_ff[23:0];
   assign reached  = dist_val < arrive_tol_ff;
   assign zero_vec = (dx_ff == 33'sd0) && (dy_ff == 33'sd0);

   // normalisation ends once either magnitude reaches 2^30
   assign normalised = (cx_ff >= 36'sd1073741824) || (cy_ff >= 36'sd1073741824) ||
                       (cy_ff <= -36'sd1073741824);

   assign cx_sh = cx_ff >>> step_ff;
   assign cy_sh = cy_ff >>> step_ff;

   // round half up from 2^-24 to 2^-13
   assign z_round   = (cz_ff + 28'sd1024) >>> 11;
   assign angle_q13 = 19'(z_round);

   assign wrap_hi  = err_ff > PI_Q13;
   assign wrap_lo  = err_ff < -PI_Q13;
   assign blocked  = scan_seen_ff && (front_min_ff < safe_dist_ff);
   assign over_tol = (err_ff > $signed({4'b0, head_tol_ff})) ||
                     (err_ff < -$signed({4'b0, head_tol_ff}));

   // gain products rounded half up and clamped
   assign ang_round = (prod_ang_ff + 36'sd2048) >>> 12;
   assign ang_r     = ang_round[23:0];
   assign lin_round = prod_lin_ff + 40'd2048;
   assign lin_r     = lin_round[39:12];
   assign ang_src   = (mode_ff == STAT_BLOCKED) ? BLOCKED_TURN : ang_r;
   assign turn_lim  = $signed({9'b0, max_turn_ff});
   assign ang_c     = (ang_src > turn_lim) ? turn_lim :
                      ((ang_src < -turn_lim) ? -turn_lim : ang_src);
   assign lin_c     = (lin_r > {5'b0, max_lin_ff}) ? {1'b0, max_lin_ff} : lin_r[23:0];

   // scan sample: restart on the first sample, keep valid ranges strictly inside the window
   assign scan_start = req_scan_first ? RANGE_INF : run_min_ff;
   assign in_window  = (req_sample_angle < FRONT_HALF_ANGLE) &&
                       (req_sample_angle > -FRONT_HALF_ANGLE);
   assign scan_cand  = (req_range_valid && in_window && (req_sample_range < scan_start)) ?
                       req_sample_range : scan_start;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && (req_cmd == CMD_TICK)) begin
               if (!armed_ff || !req_pose_valid) state_in = ST_FINISH;
               else state_in = ST_SQUARE_X;
            end
         end
         ST_SQUARE_X: state_in = ST_SQUARE_Y;
         ST_SQUARE_Y: state_in = ST_ROOT;
         ST_ROOT: begin
            if (bit_ff[0]) state_in = ST_ARRIVE;
         end
         ST_ARRIVE: begin
            if (reached) state_in = ST_FINISH;
            else if (zero_vec) state_in = ST_ANGLE;
            else state_in = ST_NORM;
         end
         ST_NORM: begin
            if (normalised) state_in = ST_ROTATE;
         end
         ST_ROTATE: begin
            if (step_ff == 5'(CORDIC_STEPS - 1)) state_in = ST_ANGLE;
         end
         ST_ANGLE: state_in = ST_WRAP;
         ST_WRAP: begin
            if (!wrap_hi && !wrap_lo) state_in = ST_MUL_ANG;
         end
         ST_MUL_ANG: state_in = ST_MUL_LIN;
         ST_MUL_LIN: state_in = ST_CLAMP;
         ST_CLAMP: state_in = ST_FINISH;
         ST_FINISH: begin
            if (load_rsp) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      idle     = 1'b0;
      load_rsp = 1'b0;
      case (state_ff)
         ST_IDLE:   idle = 1'b1;
         ST_FINISH: load_rsp = !rsp_valid_ff || !rsp_stall;
         default: begin
            idle     = 1'b0;
            load_rsp = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         max_lin_ff    <= 23'd13107;
         max_turn_ff   <= 15'd4915;
         lin_gain_ff   <= 16'd3277;
         turn_gain_ff  <= 16'd6144;
         arrive_tol_ff <= 24'd6554;
         head_tol_ff   <= 15'd2048;
         safe_dist_ff  <= 24'd131072;
      end else if (csr_valid) begin
         case (csr_index)
            REG_MAX_LIN:   max_lin_ff    <= csr_wdata[22:0];
            REG_MAX_TURN:  max_turn_ff   <= csr_wdata[14:0];
            REG_LIN_GAIN:  lin_gain_ff   <= csr_wdata[15:0];
            REG_TURN_GAIN: turn_gain_ff  <= csr_wdata[15:0];
            REG_ARRIVE:    arrive_tol_ff <= csr_wdata;
            REG_HEAD_TOL:  head_tol_ff   <= csr_wdata[14:0];
            REG_SAFE_DIST: safe_dist_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // goal and scan state
   always_ff @(posedge clock) begin
      if (reset) begin
         goal_x_ff    <= '0;
         goal_y_ff    <= '0;
         armed_ff     <= 1'b0;
         run_min_ff   <= RANGE_INF;
         front_min_ff <= RANGE_INF;
         scan_seen_ff <= 1'b0;
      end else begin
         if (idle && req_valid && (req_cmd == CMD_GOAL)) begin
            goal_x_ff <= req_pos_x;
            goal_y_ff <= req_pos_y;
            armed_ff  <= 1'b1;
         end
         if (idle && req_valid && (req_cmd == CMD_SCAN)) begin
            if (req_scan_last) begin
               front_min_ff <= scan_cand;
               scan_seen_ff <= 1'b1;
               run_min_ff   <= RANGE_INF;
            end else begin
               run_min_ff <= scan_cand;
            end
         end
         // goal reached disarms
         if ((state_ff == ST_ARRIVE) && reached) armed_ff <= 1'b0;
      end
   end

   // tick datapath, payload only
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            dx_ff      <= dx_new;
            dy_ff      <= dy_new;
            heading_ff <= req_heading;
            out_lin_ff <= '0;
            out_ang_ff <= '0;
            mode_ff    <= armed_ff ? STAT_NO_POSE : STAT_NO_GOAL;
         end
         ST_SQUARE_X: begin
            far_ff <= (ax[32:24] != 9'd0) || (ay[32:24] != 9'd0);
            rem_ff <= {2'b0, sq_prod};
         end
         ST_SQUARE_Y: begin
            rem_ff  <= rem_ff + {2'b0, sq_prod};
            root_ff <= '0;
            bit_ff  <= 50'd1 << 48;
         end
         ST_ROOT: begin
            if (root_take) begin
               rem_ff  <= rem_ff - trial;
               root_ff <= (root_ff >> 1) + bit_ff;
            end else begin
               root_ff <= root_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
         end
         ST_ARRIVE: begin
            dist_ff <= dist_val;
            step_ff <= '0;
            if (reached) begin
               mode_ff <= STAT_REACHED;
            end
            // pre-rotate into the right half plane
            if (zero_vec) begin
               cz_ff <= '0;
            end else if (dx_ff[32]) begin
               cx_ff <= -36'(dx_ff);
               cy_ff <= -36'(dy_ff);
               cz_ff <= dy_ff[32] ? -PI_Q24 : PI_Q24;
            end else begin
               cx_ff <= 36'(dx_ff);
               cy_ff <= 36'(dy_ff);
               cz_ff <= '0;
            end
         end
         ST_NORM: begin
            if (!normalised) begin
               cx_ff <= cx_ff <<< 1;
               cy_ff <= cy_ff <<< 1;
            end
         end
         ST_ROTATE: begin
            if (!cy_ff[35]) begin
               cx_ff <= cx_ff + cy_sh;
               cy_ff <= cy_ff - cx_sh;
               cz_ff <= cz_ff + atan_entry(step_ff);
            end else begin
               cx_ff <= cx_ff - cy_sh;
               cy_ff <= cy_ff + cx_sh;
               cz_ff <= cz_ff - atan_entry(step_ff);
            end
            step_ff <= step_ff + 5'd1;
         end
         ST_ANGLE: begin
            err_ff <= angle_q13 - 19'(heading_ff);
         end
         ST_WRAP: begin
            if (wrap_hi) err_ff <= err_ff - TWO_PI_Q13;
            else if (wrap_lo) err_ff <= err_ff + TWO_PI_Q13;
            else if (blocked) mode_ff <= STAT_BLOCKED;
            else if (over_tol) mode_ff <= STAT_TURNING;
            else mode_ff <= STAT_DRIVING;
         end
         ST_MUL_ANG: begin
            prod_ang_ff <= 36'($signed({1'b0, turn_gain_ff}) * err_ff);
         end
         ST_MUL_LIN: begin
            prod_lin_ff <= lin_gain_ff * dist_ff;
         end
         ST_CLAMP: begin
            out_lin_ff <= (mode_ff == STAT_DRIVING) ? $signed(lin_c) : 24'sd0;
            out_ang_ff <= ang_c[15:0];
         end
         default: ;
      endcase
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_lin_ff    <= out_lin_ff;
         rsp_ang_ff    <= out_ang_ff;
         rsp_status_ff <= mode_ff;
      end
   end

   assign req_stall   = !idle;
   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_lin_vel = rsp_lin_ff;
   assign rsp_ang_vel = rsp_ang_ff;
   assign rsp_status  = rsp_status_ff;

endmodule

FILE: verif/tb_top.sv
// tb_top: self-checking testbench of the go-to-goal steering controller
// depends on gtg_pkg and go_to_goal_steering_controller; predicts every command in a scoreboard
`timescale 1ns / 1ps

module tb_top;
   import gtg_pkg::*;

   // one request transaction, as driven on the req_ ports
   typedef struct {
      logic [1:0]         cmd;
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic signed [15:0] heading;
      logic               pose_valid;
      logic [23:0]        range;
      logic               range_valid;
      logic signed [15:0] angle;
      logic               first;
      logic               last;
   } event_t;

   // one velocity command
   typedef struct {
      logic signed [23:0] lin;
      logic signed [15:0] ang;
      logic [2:0]         status;
   } command_t;

   // scoreboard: own copy of registers and state, queue of commands still to come
   class steering_scoreboard;
      logic [22:0] max_lin;
      logic [14:0] max_turn;
      logic [15:0] lin_gain;
      logic [15:0] turn_gain;
      logic [23:0] arrive_tol;
      logic [14:0] head_tol;
      logic [23:0] safe_dist;
      longint      goal_x, goal_y;
      bit          armed;
      logic [23:0] running_min, front_min;
      bit          scan_seen;
      command_t    due_commands[$];
      int          errors;
      longint      atan_q24[20];

      function new();
         atan_q24 = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123,
                      131069, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256,
                      128, 64, 32};
         max_lin = 23'd13107;
         max_turn = 15'd4915;
         lin_gain = 16'd3277;
         turn_gain = 16'd6144;
         arrive_tol = 24'd6554;
         head_tol = 15'd2048;
         safe_dist = 24'd131072;
         goal_x = 0;
         goal_y = 0;
         armed = 0;
         running_min = 24'hFFFFFF;
         front_min = 24'hFFFFFF;
         scan_seen = 0;
         errors = 0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [23:0] data);
         case (idx)
            REG_MAX_LIN:   max_lin = data[22:0];
            REG_MAX_TURN:  max_turn = data[14:0];
            REG_LIN_GAIN:  lin_gain = data[15:0];
            REG_TURN_GAIN: turn_gain = data[15:0];
            REG_ARRIVE:    arrive_tol = data;
            REG_HEAD_TOL:  head_tol = data[14:0];
            REG_SAFE_DIST: safe_dist = data;
            default: ;
         endcase
      endfunction

      function longint root_floor(longint unsigned n);
         longint unsigned res, b;
         res = 0;
         b = 64'd1 << 62;
         while (b > n) b = b >> 2;
         while (b != 0) begin
            if (n >= res + b) begin
               n = n - (res + b);
               res = (res >> 1) + b;
            end else begin
               res = res >> 1;
            end
            b = b >> 2;
         end
         return longint'(res);
      endfunction

      function longint labs(longint v);
         return (v < 0) ? -v : v;
      endfunction

      function longint round_q(longint v, int s);
         return (v + (longint'(1) << (s - 1))) >>> s;
      endfunction

      // cordic vectoring bearing of (x, y), result in Q3.13
      function longint bearing(longint x, longint y);
         longint z, xs, ys;
         z = 0;
         if (x == 0 && y == 0) return 0;
         if (x < 0) begin
            z = (y >= 0) ? 64'sd52707179 : -64'sd52707179;
            x = -x;
            y = -y;
         end
         while (labs(x) < (longint'(1) << 30) && labs(y) < (longint'(1) << 30)) begin
            x = x * 2;
            y = y * 2;
         end
         for (int i = 0; i < 20; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
               x = x + ys;
               y = y - xs;
               z = z + atan_q24[i];
            end else begin
               x = x - ys;
               y = y + xs;
               z = z - atan_q24[i];
            end
         end
         return round_q(z, 11);
      endfunction

      function longint limit(longint v, longint lim);
         if (v > lim) return lim;
         if (v < -lim) return -lim;
         return v;
      endfunction

      // note an accepted request transaction and queue any command it causes
      function void note_event(event_t ev);
         command_t c;
         longint dx, dy, dist_q, err, lin, ang;
         case (ev.cmd)
            CMD_GOAL: begin
               goal_x = ev.px;
               goal_y = ev.py;
               armed = 1;
            end
            CMD_SCAN: begin
               if (ev.first) running_min = 24'hFFFFFF;
               if (ev.range_valid && labs(ev.angle) < 4289 && ev.range < running_min)
                  running_min = ev.range;
               if (ev.last) begin
                  front_min = running_min;
                  scan_seen = 1;
                  running_min = 24'hFFFFFF;
               end
            end
            CMD_TICK: begin
               lin = 0;
               ang = 0;
               if (!armed) begin
                  c.status = STAT_NO_GOAL;
               end else if (!ev.pose_valid) begin
                  c.status = STAT_NO_POSE;
               end else begin
                  dx = goal_x - longint'(ev.px);
                  dy = goal_y - longint'(ev.py);
                  if (labs(dx) >= (longint'(1) << 24) || labs(dy) >= (longint'(1) << 24))
                     dist_q = 64'hFFFFFF;
                  else
                     dist_q = root_floor(dx * dx + dy * dy);
                  if (dist_q > 64'hFFFFFF) dist_q = 64'hFFFFFF;
                  if (dist_q < arrive_tol) begin
                     armed = 0;
                     c.status = STAT_REACHED;
                  end else begin
                     err = bearing(dx, dy) - longint'(ev.heading);
                     while (err > 25736) err = err - 51472;
                     while (err < -25736) err = err + 51472;
                     if (scan_seen && front_min < safe_dist) begin
                        ang = 3277;
                        c.status = STAT_BLOCKED;
                     end else if (labs(err) > head_tol) begin
                        ang = round_q(longint'(turn_gain) * err, 12);
                        c.status = STAT_TURNING;
                     end else begin
                        lin = round_q(longint'(lin_gain) * dist_q, 12);
                        ang = round_q(longint'(turn_gain) * err, 12);
                        c.status = STAT_DRIVING;
                     end
                     lin = limit(lin, max_lin);
                     ang = limit(ang, max_turn);
                  end
               end
               c.lin = lin[23:0];
               c.ang = ang[15:0];
               due_commands.push_back(c);
            end
            default: ;
         endcase
      endfunction

      // compare a command seen on the rsp_ side with the oldest one due
      function void check_command(command_t got);
         command_t want;
         if (due_commands.size() == 0) begin
            $display("%0t: command with none due: lin %0d ang %0d status %0d",
                     $time, got.lin, got.ang, got.status);
            errors++;
            return;
         end
         want = due_commands.pop_front();
         if (got.lin !== want.lin) begin
            $display("%0t: lin_vel expected %0d got %0d", $time, want.lin, got.lin);
            errors++;
         end
         if (got.ang !== want.ang) begin
            $display("%0t: ang_vel expected %0d got %0d", $time, want.ang, got.ang);
            errors++;
         end
         if (got.status !== want.status) begin
            $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
            errors++;
         end
      endfunction
   endclass

   logic               clock = 0;
   logic               reset = 1;
   logic               req_valid = 0;
   logic               req_stall;
   logic [1:0]         req_cmd = CMD_GOAL;
   logic signed [31:0] req_pos_x = '0;
   logic signed [31:0] req_pos_y = '0;
   logic signed [15:0] req_heading = '0;
   logic               req_pose_valid = 0;
   logic [23:0]        req_sample_range = '0;
   logic               req_range_valid = 0;
   logic signed [15:0] req_sample_angle = '0;
   logic               req_scan_first = 0;
   logic               req_scan_last = 0;
   logic               rsp_valid;
   logic               rsp_stall = 0;
   logic signed [23:0] rsp_lin_vel;
   logic signed [15:0] rsp_ang_vel;
   logic [2:0]         rsp_status;
   logic               csr_valid = 0;
   logic               csr_ready;
   logic [2:0]         csr_index = '0;
   logic [23:0]        csr_wdata = '0;

   steering_scoreboard sb = new();

   int idle_pct = 28;          // chance in a hundred that either side idles
   int hold_asks = 0;          // bumped by the stimulus to ask for a long rsp_ hold-off
   int hold_done = 0;
   int hold_left = 0;
   int n_ticks = 0, n_scans = 0, n_goals = 0, n_regs = 0, n_cmds = 0;
   logic signed [31:0] goal_x = 0, goal_y = 0;   // last goal sent, to aim ticks near it

   go_to_goal_steering_controller u_dut (.*);

   always #6 clock = ~clock;

   // receiver: random stalls, or a long counted hold-off when asked
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 0;
      end else if (hold_asks != hold_done) begin
         hold_done <= hold_asks;
         hold_left <= 400;
         rsp_stall <= 1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < idle_pct);
      end
   end

   // every transaction taken on the rsp_ side goes to the scoreboard
   always @(posedge clock) begin
      command_t got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.lin = rsp_lin_vel;
         got.ang = rsp_ang_vel;
         got.status = rsp_status;
         sb.check_command(got);
         n_cmds++;
      end
   end

   // watchdog, far beyond the slowest correct run
   initial begin
      #30000000;
      $display("tb: failure");
      $finish;
   end

   // one request transaction; valid stays up into the next one unless a gap is drawn
   task automatic send_event(input event_t ev);
      req_cmd <= ev.cmd;
      req_pos_x <= ev.px;
      req_pos_y <= ev.py;
      req_heading <= ev.heading;
      req_pose_valid <= ev.pose_valid;
      req_sample_range <= ev.range;
      req_range_valid <= ev.range_valid;
      req_sample_angle <= ev.angle;
      req_scan_first <= ev.first;
      req_scan_last <= ev.last;
      req_valid <= 1;
      do @(posedge clock); while (req_stall);
      sb.note_event(ev);
      case (ev.cmd)
         CMD_GOAL: begin
            n_goals++;
            goal_x = ev.px;
            goal_y = ev.py;
         end
         CMD_SCAN: n_scans++;
         CMD_TICK: n_ticks++;
         default: ;
      endcase
      if ($urandom_range(99) < idle_pct) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   // sender pauses until every due command has come back, then lets the block settle
   task automatic drain();
      req_valid <= 0;
      while (sb.due_commands.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [23:0] data);
      csr_index <= idx;
      csr_wdata <= data;
      csr_valid <= 1;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, data);
      n_regs++;
      csr_valid <= 0;
      @(posedge clock);
   endtask

   task automatic write_all(input logic [23:0] v0, v1, v2, v3, v4, v5, v6);
      write_reg(REG_MAX_LIN, v0);
      write_reg(REG_MAX_TURN, v1);
      write_reg(REG_LIN_GAIN, v2);
      write_reg(REG_TURN_GAIN, v3);
      write_reg(REG_ARRIVE, v4);
      write_reg(REG_HEAD_TOL, v5);
      write_reg(REG_SAFE_DIST, v6);
   endtask

   function automatic event_t blank(logic [1:0] cmd);
      event_t ev;
      ev.cmd = cmd;
      ev.px = $urandom;
      ev.py = $urandom;
      ev.heading = 16'($urandom);
      ev.pose_valid = 1'($urandom);
      ev.range = 24'($urandom);
      ev.range_valid = 1'($urandom);
      ev.angle = 16'($urandom);
      ev.first = 0;
      ev.last = 0;
      return ev;
   endfunction

   function automatic event_t goal_ev(int x, int y);
      event_t ev = blank(CMD_GOAL);
      ev.px = x;
      ev.py = y;
      return ev;
   endfunction

   function automatic event_t tick_ev(int x, int y, int hd, bit pv);
      event_t ev = blank(CMD_TICK);
      ev.px = x;
      ev.py = y;
      ev.heading = 16'(hd);
      ev.pose_valid = pv;
      return ev;
   endfunction

   function automatic event_t scan_ev(int r, bit rv, int a, bit f, bit l);
      event_t ev = blank(CMD_SCAN);
      ev.range = 24'(r);
      ev.range_valid = rv;
      ev.angle = 16'(a);
      ev.first = f;
      ev.last = l;
      return ev;
   endfunction

   function automatic int offset_of();
      int k = $urandom_range(0, 22);
      return int'($urandom_range(0, 2 << k)) - (1 << k);
   endfunction

   // tick mostly near the current goal, sometimes anywhere
   function automatic event_t rand_tick();
      event_t ev;
      if ($urandom_range(9) == 0)
         ev = tick_ev($urandom, $urandom, 0, 1);
      else
         ev = tick_ev(goal_x - offset_of(), goal_y - offset_of(), 0, 1);
      ev.heading = 16'(int'($urandom_range(0, 51472)) - 25736);
      ev.pose_valid = ($urandom_range(9) != 0);
      return ev;
   endfunction

   function automatic event_t rand_goal();
      if ($urandom_range(7) == 0) return goal_ev($urandom, $urandom);
      return goal_ev(int'($urandom_range(0, 1 << 23)) - (1 << 22),
                     int'($urandom_range(0, 1 << 23)) - (1 << 22));
   endfunction

   // a whole scan with random content, angles around the front window edge
   task automatic send_scan();
      int n = $urandom_range(1, 8);
      int r;
      for (int i = 0; i < n; i++) begin
         r = ($urandom_range(1) == 0) ? $urandom_range(0, 1 << 19) : $urandom_range(0, 24'hFFFFFF);
         send_event(scan_ev(r, $urandom_range(9) != 0, int'($urandom_range(0, 10000)) - 5000,
                            i == 0, i == n - 1));
      end
   endtask

   // random phase: mostly well-formed goals, scans and ticks, some noise
   task automatic random_phase(input int items, input bit with_hold);
      int sent = 0;
      int pick;
      int scans_before;
      bit held = 0;
      while (sent < items) begin
         pick = $urandom_range(99);
         if (with_hold && !held && sent >= items / 2) begin
            hold_asks++;
            held = 1;
         end
         if (pick < 10) begin
            send_event(rand_goal());
            sent++;
         end else if (pick < 35) begin
            scans_before = n_scans;
            send_scan();
            sent += n_scans - scans_before;
         end else if (pick < 90) begin
            send_event(rand_tick());
            sent++;
         end else if (pick < 96) begin
            send_event(blank(CMD_SCAN));
            sent++;
         end else begin
            send_event(blank(2'd3));   // unknown kind, ignored
            sent++;
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: default registers
      send_event(tick_ev(0, 0, 0, 1));                       // no goal armed
      send_event(goal_ev(0, 0));
      send_event(tick_ev(5, 5, 0, 0));                       // pose unknown
      send_event(tick_ev(3, -3, 0, 1));                      // reached, disarms
      send_event(tick_ev(1 << 20, 0, 0, 1));                 // disarmed again
      send_event(goal_ev(32'h7FFFFFFF, 32'h80000000));
      send_event(tick_ev(32'h80000000, 32'h7FFFFFFF, 25736, 1));  // oversized distance
      send_event(goal_ev(1 << 20, 0));
      send_event(tick_ev(0, 0, 0, 1));                       // straight ahead, driving
      send_event(tick_ev(1 << 21, 1, -25736, 1));            // goal behind, heading -pi faces it, driving
      send_event(tick_ev(1 << 21, -1, 25736, 1));
      send_event(scan_ev(1, 1, 4288, 1, 0));                 // inside the window
      send_event(scan_ev(0, 1, 4289, 0, 0));                 // just outside, ignored
      send_event(scan_ev(0, 0, 0, 0, 0));                    // invalid range, ignored
      send_event(scan_ev(24'hFFFFFF, 1, -4288, 0, 1));       // commit
      send_event(tick_ev(0, 0, 0, 1));                       // blocked
      send_event(scan_ev(24'hFFFFFF, 1, -32768, 1, 1));      // one-sample scan clears
      send_event(tick_ev(0, 0, 0, 1));
      send_event(blank(2'd3));
      drain();

      // extremes: widest limits, no arrival band, every heading counts as aligned
      write_all(24'h7FFFFF, 24'h7FFF, 24'hFFFF, 24'hFFFF, 24'd0, 24'd25736, 24'd0);
      send_event(goal_ev(0, 0));
      send_event(tick_ev(0, 0, 0, 1));                       // zero vector, angle 0
      send_event(tick_ev(-(1 << 23), 0, 25736, 1));
      random_phase(300, 1);                                  // long hold-off mid phase
      drain();

      // all limits and gains at zero, huge arrival band
      write_all(24'd0, 24'd0, 24'd0, 24'd0, 24'hFFFFFF, 24'd0, 24'hFFFFFF);
      write_reg(3'd7, 24'hFFFFFF);                           // index out of range
      random_phase(200, 0);
      drain();

      // moderate random registers, no idling for a long stretch
      write_all(24'($urandom_range(0, 24'h7FFFFF)), 24'($urandom_range(0, 24'h7FFF)),
                24'($urandom_range(0, 24'hFFFF)), 24'($urandom_range(0, 24'hFFFF)),
                24'($urandom_range(0, 1 << 18)), 24'($urandom_range(0, 25736)),
                24'($urandom_range(0, 1 << 19)));
      idle_pct = 0;
      random_phase(250, 0);
      idle_pct = 28;
      drain();

      // back to reset-like values with random traffic
      write_all(24'd13107, 24'd4915, 24'd3277, 24'd6144, 24'd6554, 24'd2048, 24'd131072);
      random_phase(500, 1);
      drain();

      $display("run covered %0d ticks, %0d scan samples, %0d goals, %0d register writes",
               n_ticks, n_scans, n_goals, n_regs);
      $display("%0d commands checked, %0d mismatches", n_cmds, sb.errors);
      if (sb.errors == 0 && sb.due_commands.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
